// ----- design/iet_pkg.sv -----
package iet_pkg;

    // button count of the mouse items
    localparam int NUM_BUTTONS = 3;

    // event slots of one job, emitted lowest first
    localparam int SLOT_KEY     = 0;
    localparam int SLOT_MOTION  = 1;
    localparam int SLOT_PRESS   = 2;
    localparam int SLOT_RELEASE = 3;
    localparam int SLOT_BUTTON0 = 4;
    localparam int NUM_SLOTS    = SLOT_BUTTON0 + NUM_BUTTONS;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] EVT_KEY    = 2'd0;
    localparam logic [1:0] EVT_MOTION = 2'd1;
    localparam logic [1:0] EVT_BUTTON = 2'd2;

    localparam logic KIND_KEY   = 1'b0;
    localparam logic KIND_MOUSE = 1'b1;

    localparam logic BTN_PRIMARY   = 1'b0;
    localparam logic BTN_SECONDARY = 1'b1;

    localparam logic [7:0] SPEED_RESET = 8'd8;

    localparam logic [2:0] REG_MOUSE_SPEED     = 3'd0;
    localparam logic [2:0] REG_CTRL_KEY        = 3'd1;
    localparam logic [2:0] REG_LEFT_KEY        = 3'd2;
    localparam logic [2:0] REG_RIGHT_KEY       = 3'd3;
    localparam logic [2:0] REG_UP_KEY          = 3'd4;
    localparam logic [2:0] REG_DOWN_KEY        = 3'd5;
    localparam logic [2:0] REG_PRIMARY_CLICK   = 3'd6;
    localparam logic [2:0] REG_SECONDARY_CLICK = 3'd7;

    typedef struct packed {
        logic [7:0] mouse_speed;
        logic [7:0] ctrl_key;
        logic [7:0] left_key;
        logic [7:0] right_key;
        logic [7:0] up_key;
        logic [7:0] down_key;
        logic [7:0] primary_click_key;
        logic [7:0] secondary_click_key;
    } cfg_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0]   mask;
        logic [7:0]             code;
        logic                   released;
        logic signed [15:0]     move_x;
        logic signed [15:0]     move_y;
        logic                   click_btn;
        logic [NUM_BUTTONS-1:0] buttons;
    } job_t;

endpackage

// ----- design/iet_front.sv -----
module iet_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  iet_pkg::cfg_t                     cfg,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [7:0]                        s_key_code,
    input  logic                              s_key_released,
    input  logic signed [15:0]                s_mouse_dx,
    input  logic signed [15:0]                s_mouse_dy,
    input  logic [iet_pkg::NUM_BUTTONS-1:0]   s_mouse_buttons,
    input  logic                              q_full,
    output logic                              push,
    output iet_pkg::job_t                     push_job
);
    import iet_pkg::*;

    logic                   ctrl_held_reg, ctrl_held_next;
    logic [NUM_BUTTONS-1:0] button_state_reg, button_state_next;
    logic                   accept;
    logic                   ctrl_now;
    logic [15:0]            speed16;
    logic [15:0]            neg_speed;
    job_t                   job;

    assign s_ready   = !q_full;
    assign accept    = s_valid && !q_full;
    assign speed16   = {8'd0, cfg.mouse_speed};
    assign neg_speed = 16'd0 - speed16;
    assign ctrl_now  = (s_key_code == cfg.ctrl_key) ? !s_key_released : ctrl_held_reg;

    always_comb begin
        job = '0;
        if (s_kind == KIND_KEY) begin
            job.mask[SLOT_KEY] = 1'b1;
            job.code           = s_key_code;
            job.released       = s_key_released;
            if (ctrl_now && !s_key_released) begin
                if (s_key_code == cfg.left_key) begin
                    job.mask[SLOT_MOTION] = 1'b1;
                    job.move_x            = neg_speed;
                end else if (s_key_code == cfg.right_key) begin
                    job.mask[SLOT_MOTION] = 1'b1;
                    job.move_x            = speed16;
                end else if (s_key_code == cfg.up_key) begin
                    job.mask[SLOT_MOTION] = 1'b1;
                    job.move_y            = neg_speed;
                end else if (s_key_code == cfg.down_key) begin
                    job.mask[SLOT_MOTION] = 1'b1;
                    job.move_y            = speed16;
                end else if (s_key_code == cfg.primary_click_key) begin
                    job.mask[SLOT_PRESS]   = 1'b1;
                    job.mask[SLOT_RELEASE] = 1'b1;
                    job.click_btn          = BTN_PRIMARY;
                end else if (s_key_code == cfg.secondary_click_key) begin
                    job.mask[SLOT_PRESS]   = 1'b1;
                    job.mask[SLOT_RELEASE] = 1'b1;
                    job.click_btn          = BTN_SECONDARY;
                end
            end
        end else begin
            if (s_mouse_dx != 16'sd0 || s_mouse_dy != 16'sd0) begin
                job.mask[SLOT_MOTION] = 1'b1;
                job.move_x            = s_mouse_dx;
                job.move_y            = s_mouse_dy;
            end
            job.mask[SLOT_BUTTON0 +: NUM_BUTTONS] = s_mouse_buttons ^ button_state_reg;
            job.buttons                           = s_mouse_buttons;
        end
    end

    // items with no event update state only
    assign push     = accept && (job.mask != '0);
    assign push_job = job;

    always_comb begin
        ctrl_held_next    = ctrl_held_reg;
        button_state_next = button_state_reg;
        if (accept) begin
            if (s_kind == KIND_KEY) begin
                ctrl_held_next = ctrl_now;
            end else begin
                button_state_next = s_mouse_buttons;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_held_reg    <= 1'b0;
            button_state_reg <= '0;
        end else begin
            ctrl_held_reg    <= ctrl_held_next;
            button_state_reg <= button_state_next;
        end
    end

endmodule

// ----- design/iet_queue.sv -----
module iet_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  iet_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output iet_pkg::job_t q_job
);
    import iet_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_job   = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- design/iet_back.sv -----
module iet_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  iet_pkg::job_t      q_job,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_event_type,
    output logic [7:0]         m_event_code,
    output logic               m_action,
    output logic signed [15:0] m_move_x,
    output logic signed [15:0] m_move_y,
    output logic               m_last
);
    import iet_pkg::*;

    logic [NUM_SLOTS-1:0] mask_reg, mask_next;
    job_t                 job_reg, job_next;
    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           type_reg, type_next;
    logic [7:0]           code_reg, code_next;
    logic                 action_reg, action_next;
    logic signed [15:0]   move_x_reg, move_x_next;
    logic signed [15:0]   move_y_reg, move_y_next;
    logic                 last_reg, last_next;

    logic [NUM_SLOTS-1:0] sel_bit;
    logic [NUM_SLOTS-1:0] rest;
    logic                 out_free;
    logic                 emit;

    // lowest pending slot goes next
    assign sel_bit  = mask_reg & (~mask_reg + 1'b1);
    assign rest     = mask_reg & ~sel_bit;
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = out_free && (mask_reg != '0);
    assign pop      = q_valid && ((mask_reg == '0) || (emit && rest == '0));

    always_comb begin
        type_next   = type_reg;
        code_next   = code_reg;
        action_next = action_reg;
        move_x_next = move_x_reg;
        move_y_next = move_y_reg;
        last_next   = last_reg;
        if (emit) begin
            type_next   = EVT_BUTTON;
            code_next   = '0;
            action_next = 1'b0;
            move_x_next = '0;
            move_y_next = '0;
            last_next   = (rest == '0);
            if (sel_bit[SLOT_KEY]) begin
                type_next   = EVT_KEY;
                code_next   = job_reg.code;
                action_next = job_reg.released;
            end else if (sel_bit[SLOT_MOTION]) begin
                type_next   = EVT_MOTION;
                move_x_next = job_reg.move_x;
                move_y_next = job_reg.move_y;
            end else if (sel_bit[SLOT_PRESS]) begin
                code_next = {7'd0, job_reg.click_btn};
            end else if (sel_bit[SLOT_RELEASE]) begin
                code_next   = {7'd0, job_reg.click_btn};
                action_next = 1'b1;
            end else begin
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    if (sel_bit[SLOT_BUTTON0 + i]) begin
                        code_next   = 8'(i);
                        action_next = !job_reg.buttons[i];
                    end
                end
            end
        end
    end

    always_comb begin
        mask_next    = emit ? rest : mask_reg;
        job_next     = job_reg;
        m_valid_next = m_valid_reg;
        if (pop) begin
            mask_next = q_job.mask;
            job_next  = q_job;
        end
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        type_reg   <= type_next;
        code_reg   <= code_next;
        action_reg <= action_next;
        move_x_reg <= move_x_next;
        move_y_reg <= move_y_next;
        last_reg   <= last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_event_type = type_reg;
    assign m_event_code = code_reg;
    assign m_action     = action_reg;
    assign m_move_x     = move_x_reg;
    assign m_move_y     = move_y_reg;
    assign m_last       = last_reg;

endmodule

// ----- design/input_event_translator.sv -----
// Input event translator: keyboard and mouse words in, window-manager
// event words out, in order.
// Input channel (s_*): one word per keyboard or mouse item, valid/ready.
// Output channel (m_*): one event per word, m_last marks the final event
// caused by an input word. A key word gives 1 to 3 events, a mouse word
// 0 to 4; a mouse word that changes nothing gives no event at all.
// Config: APB-style port, eight 8-bit registers at byte offsets 4*i;
// writes land on the access cycle, pready is tied high, reads return data.
// Path: an accepted word goes into the queue, then the back end's job
// register, then the output register. Throughput: one event per cycle
// while the back end's single output register is free; it sets that.
// The front end classifies and updates control/button state at accept and
// queues a job (2 deep); the back end walks the job's event slots.
// Reset: control not held, all buttons released, mouse_speed 8, key codes
// 0, queue and output empty.
// Receiver stall: the output word holds; the queue fills, then s_ready
// drops until the back end drains.
module input_event_translator (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [4:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // input words
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [7:0]                        s_key_code,
    input  logic                              s_key_released,
    input  logic signed [15:0]                s_mouse_dx,
    input  logic signed [15:0]                s_mouse_dy,
    input  logic [iet_pkg::NUM_BUTTONS-1:0]   s_mouse_buttons,
    // event words
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_event_type,
    output logic [7:0]                        m_event_code,
    output logic                              m_action,
    output logic signed [15:0]                m_move_x,
    output logic signed [15:0]                m_move_y,
    output logic                              m_last
);
    import iet_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       cfg_wr;
    logic [2:0] reg_idx;
    logic [7:0] rd_val;

    logic       q_full, push, pop, q_valid;
    job_t       push_job, q_job;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // register write
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (reg_idx)
                REG_MOUSE_SPEED:     cfg_next.mouse_speed         = pwdata[7:0];
                REG_CTRL_KEY:        cfg_next.ctrl_key            = pwdata[7:0];
                REG_LEFT_KEY:        cfg_next.left_key            = pwdata[7:0];
                REG_RIGHT_KEY:       cfg_next.right_key           = pwdata[7:0];
                REG_UP_KEY:          cfg_next.up_key              = pwdata[7:0];
                REG_DOWN_KEY:        cfg_next.down_key            = pwdata[7:0];
                REG_PRIMARY_CLICK:   cfg_next.primary_click_key   = pwdata[7:0];
                REG_SECONDARY_CLICK: cfg_next.secondary_click_key = pwdata[7:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // register read
    always_comb begin
        case (reg_idx)
            REG_MOUSE_SPEED:     rd_val = cfg_reg.mouse_speed;
            REG_CTRL_KEY:        rd_val = cfg_reg.ctrl_key;
            REG_LEFT_KEY:        rd_val = cfg_reg.left_key;
            REG_RIGHT_KEY:       rd_val = cfg_reg.right_key;
            REG_UP_KEY:          rd_val = cfg_reg.up_key;
            REG_DOWN_KEY:        rd_val = cfg_reg.down_key;
            REG_PRIMARY_CLICK:   rd_val = cfg_reg.primary_click_key;
            REG_SECONDARY_CLICK: rd_val = cfg_reg.secondary_click_key;
            default:             rd_val = '0;
        endcase
    end

    assign prdata = {24'd0, rd_val};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{mouse_speed: SPEED_RESET, default: 8'd0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: accept, classify, update state
    iet_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_key_code      (s_key_code),
        .s_key_released  (s_key_released),
        .s_mouse_dx      (s_mouse_dx),
        .s_mouse_dy      (s_mouse_dy),
        .s_mouse_buttons (s_mouse_buttons),
        .q_full          (q_full),
        .push            (push),
        .push_job        (push_job)
    );

    // job queue between the two halves
    iet_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    // back end: one event per cycle into the output register while it is free
    iet_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_job        (q_job),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_type (m_event_type),
        .m_event_code (m_event_code),
        .m_action     (m_action),
        .m_move_x     (m_move_x),
        .m_move_y     (m_move_y),
        .m_last       (m_last)
    );

endmodule
